// ----- rtl/sseq_pkg.sv -----
// ----------------------------------------------------------------------------
// sseq_pkg: shared types and constants of the step sequencer
// Holds the event codes, field widths and the just-scale pitch table.
// ----------------------------------------------------------------------------
package sseq_pkg;

    // The step count must be a power of two so that step arithmetic wraps by width.
    localparam int STEP_COUNT = 8;
    localparam int STEP_W     = $clog2(STEP_COUNT);

    localparam int OP_W     = 3;
    localparam int KNOB_W   = 16;
    localparam int DELTA_W  = 4;
    localparam int INC_W    = 16;
    localparam int TEMPO_W  = 9;
    localparam int PHASE_W  = 32;
    localparam int PITCH_W  = 18;
    localparam int IDX_W    = 4;

    typedef logic [OP_W-1:0]    op_t;
    typedef logic [IDX_W-1:0]   pidx_t;
    typedef logic [PITCH_W-1:0] pitch_t;

    localparam op_t OP_TICK     = 3'd0;
    localparam op_t OP_MODE     = 3'd1;
    localparam op_t OP_MOVE     = 3'd2;
    localparam op_t OP_INTERVAL = 3'd3;
    localparam op_t OP_TOGGLE   = 3'd4;
    localparam op_t OP_TEMPO    = 3'd5;

    localparam logic [INC_W-1:0]   INC_RESET   = 16'd746;
    localparam logic [TEMPO_W-1:0] TEMPO_RESET = 9'd120;
    localparam logic [TEMPO_W-1:0] TEMPO_MIN   = 9'd100;

    // Pitch index is the interval plus seven; index seven is 440 Hz.
    localparam pidx_t PIDX_RESET = 4'd7;
    localparam pitch_t PITCH_MIN = 18'd30037;

    function automatic pitch_t pitch_lookup(input pidx_t idx);
        pitch_t p;
        case (idx)
            4'd0:    p = 18'd30037;
            4'd1:    p = 18'd33792;
            4'd2:    p = 18'd37547;
            4'd3:    p = 18'd42240;
            4'd4:    p = 18'd45056;
            4'd5:    p = 18'd50062;
            4'd6:    p = 18'd56320;
            4'd7:    p = 18'd112640;
            4'd8:    p = 18'd112640;
            4'd9:    p = 18'd126720;
            4'd10:   p = 18'd140800;
            4'd11:   p = 18'd150187;
            4'd12:   p = 18'd168960;
            4'd13:   p = 18'd187733;
            default: p = 18'd211200;
        endcase
        return p;
    endfunction

endpackage

// ----- rtl/step_sequencer_gate_pitch.sv -----
// ----------------------------------------------------------------------------
// step_sequencer_gate_pitch: eight-step gate sequencer with per-step pitch
// Advances a tempo-driven phase on sample ticks and applies edit events.
// ----------------------------------------------------------------------------
// Each input transaction on the s_axis channel is either one audio sample tick
// or one control event, selected by s_axis_tuser. Every input transaction
// produces exactly one output transaction on m_axis carrying the sequencer
// state after that event: play step, edit step, gate, audio enable, pitch in
// Hz times 256 and the display fields.
// The sequencer state is updated at the edge that accepts the input, and the
// result is captured in the output register at the same edge, so the result
// appears in the cycle after acceptance. One transaction is accepted per cycle while the output is not stalled.
// The throughput is set by the single output register: while it holds a result
// that the receiver has not taken, s_axis_tready is low and the state holds.
// The phase increment per BPM is written through cfg_wr_en and cfg_wr_data; the user must write it
// only while no transaction is in flight, as the block does not enforce this.
// Reset clears the phase, both step indices, all on bits and the output
// valid, sets all intervals to 440 Hz, tempo to 120 BPM and edit mode.
// ----------------------------------------------------------------------------
module step_sequencer_gate_pitch
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // knob_value[15:0], step_delta[19:16], zero[23:20]
    input  logic [23:0] s_axis_tdata,
    // op[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // play_step[2:0], edit_index[5:3], gate_out[6], audio_enable[7],
    // pitch_hz_q8[25:8], display_step[28:26], indicator[29], zero[31:30]
    output logic [31:0] m_axis_tdata,
    // view_mode[0]
    output logic [0:0]  m_axis_tuser
);

    localparam int SC = sseq_pkg::STEP_COUNT;
    localparam int SW = sseq_pkg::STEP_W;

    logic [sseq_pkg::INC_W-1:0]   inc_reg;
    logic [sseq_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [SW-1:0]                cur_reg, cur_next;
    logic [SW-1:0]                sel_reg, sel_next;
    logic [SC-1:0]                on_reg, on_next;
    sseq_pkg::pidx_t              ival_reg [SC];
    sseq_pkg::pidx_t              ival_next [SC];
    logic [sseq_pkg::TEMPO_W-1:0] tempo_reg, tempo_next;
    logic                         mode_reg, mode_next;
    logic                         latch_reg, latch_next;

    logic                         out_valid_reg;
    logic [31:0]                  out_data_reg, out_data_next;
    logic                         out_view_reg;

    logic                         accept;
    sseq_pkg::op_t                op;
    logic [sseq_pkg::KNOB_W-1:0]  knob;
    logic [SW-1:0]                delta_ext;
    logic [24:0]                  step_inc;
    logic [sseq_pkg::PHASE_W:0]   phase_sum;
    logic [19:0]                  ival_prod;
    logic [24:0]                  tempo_prod;
    logic [SW-1:0]                cur_inc;
    logic                         gate;
    logic [SW-1:0]                disp;
    logic                         ind;

    assign op            = s_axis_tuser;
    assign knob          = s_axis_tdata[15:0];
    assign delta_ext     = SW'($signed(s_axis_tdata[19:16]));
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign step_inc   = 25'(tempo_reg) * 25'(inc_reg);
    assign phase_sum  = {1'b0, phase_reg} + {8'd0, step_inc};
    assign ival_prod  = 20'(knob) * 20'd14 + 20'd32768;
    assign tempo_prod = 25'(knob) * 25'd300;
    assign cur_inc    = cur_reg + SW'(1);

    always_comb
    begin
        phase_next = phase_reg;
        cur_next   = cur_reg;
        sel_next   = sel_reg;
        on_next    = on_reg;
        ival_next  = ival_reg;
        tempo_next = tempo_reg;
        mode_next  = mode_reg;
        latch_next = latch_reg;
        case (op)
            sseq_pkg::OP_TICK:
            begin
                phase_next = phase_sum[sseq_pkg::PHASE_W-1:0];
                if (phase_sum[sseq_pkg::PHASE_W])
                begin
                    cur_next   = cur_inc;
                    latch_next = on_reg[cur_inc];
                end
            end
            sseq_pkg::OP_MODE:
            begin
                mode_next = !mode_reg;
            end
            sseq_pkg::OP_MOVE:
            begin
                if (!mode_reg)
                begin
                    sel_next = sel_reg + delta_ext;
                end
            end
            sseq_pkg::OP_INTERVAL:
            begin
                if (!mode_reg)
                begin
                    ival_next[sel_reg] = ival_prod[19:16];
                end
            end
            sseq_pkg::OP_TOGGLE:
            begin
                if (!mode_reg)
                begin
                    on_next[sel_reg] = !on_reg[sel_reg];
                end
            end
            sseq_pkg::OP_TEMPO:
            begin
                if (!mode_reg)
                begin
                    tempo_next = sseq_pkg::TEMPO_MIN + tempo_prod[24:16];
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    always_comb
    begin
        gate = !phase_next[sseq_pkg::PHASE_W-1] && latch_next;
        if (mode_next)
        begin
            disp = cur_next;
            ind  = latch_next;
        end
        else
        begin
            disp = sel_next;
            ind  = on_next[sel_next];
        end
        out_data_next = {2'b00, ind, 3'(disp),
                         sseq_pkg::pitch_lookup(ival_next[cur_next]),
                         on_next[cur_next], gate, 3'(sel_next), 3'(cur_next)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inc_reg       <= sseq_pkg::INC_RESET;
            phase_reg     <= '0;
            cur_reg       <= '0;
            sel_reg       <= '0;
            on_reg        <= '0;
            for (int i = 0; i < SC; i++)
            begin
                ival_reg[i] <= sseq_pkg::PIDX_RESET;
            end
            tempo_reg     <= sseq_pkg::TEMPO_RESET;
            mode_reg      <= 1'b0;
            latch_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                inc_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                phase_reg <= phase_next;
                cur_reg   <= cur_next;
                sel_reg   <= sel_next;
                on_reg    <= on_next;
                ival_reg  <= ival_next;
                tempo_reg <= tempo_next;
                mode_reg  <= mode_next;
                latch_reg <= latch_next;
            end
            if (s_axis_tready)
            begin
                out_valid_reg <= s_axis_tvalid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
            out_view_reg <= mode_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_view_reg;

    // An accepted transaction always leaves a result behind it.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_axis_tvalid)
    else $error("accepted transaction produced no result");

    // A mode event flips the display mode.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && op == sseq_pkg::OP_MODE |=> mode_reg != $past(mode_reg))
    else $error("mode event did not toggle the mode");

    // In edit mode the display shows the edit step.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[28:26] == m_axis_tdata[5:3])
    else $error("edit display differs from edit step");

    // In view mode an open gate implies the latched gate indicator.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] && m_axis_tdata[6] |-> m_axis_tdata[29])
    else $error("gate open without latched gate");

    // The pitch never falls below the lowest table entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[25:8] >= sseq_pkg::PITCH_MIN)
    else $error("pitch out of table range");

endmodule

// ----- tb/sv/sseq_result_checker.sv -----
// ----------------------------------------------------------------------------
// sseq_result_checker: result predictor and comparator for the step sequencer
// Follows every transaction on both stream channels and every increment write.
// It keeps its own copy of the sequencer state and computes the expected view
// for each accepted event. Each output transaction is compared field by field
// with the oldest expected view.
// ----------------------------------------------------------------------------
module sseq_result_checker
    import sseq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic [0:0]  m_tuser,
    output int          fail_count,
    output int          pending_count,
    output int          results_checked,
    output int          step_advances
);

    typedef logic [STEP_W-1:0] step_t;

    typedef struct packed {
        step_t  play;
        step_t  edit;
        logic   gate;
        logic   audio_en;
        pitch_t pitch;
        logic   view;
        step_t  disp;
        logic   ind;
    } seq_view_t;

    pitch_t just_q8 [15] = '{
        18'd30037, 18'd33792, 18'd37547, 18'd42240, 18'd45056, 18'd50062, 18'd56320,
        18'd112640,
        18'd112640, 18'd126720, 18'd140800, 18'd150187, 18'd168960, 18'd187733,
        18'd211200
    };

    logic [PHASE_W-1:0]    phase;
    step_t                 play_idx;
    step_t                 edit_idx;
    logic [STEP_COUNT-1:0] step_on;
    logic signed [3:0]     interval [STEP_COUNT];
    logic [TEMPO_W-1:0]    tempo;
    logic [INC_W-1:0]      inc;
    logic                  view_bit;
    logic                  gate_bit;

    seq_view_t expected_views [$];
    seq_view_t fresh_view;
    seq_view_t oldest_view;

    task automatic clear_sequencer();
        phase    = '0;
        play_idx = '0;
        edit_idx = '0;
        step_on  = '0;
        for (int i = 0; i < STEP_COUNT; i++)
            interval[i] = 4'sd0;
        tempo    = TEMPO_RESET;
        inc      = INC_RESET;
        view_bit = 1'b0;
        gate_bit = 1'b0;
    endtask

    task automatic apply_event(input op_t op, input logic [KNOB_W-1:0] k,
                               input logic [DELTA_W-1:0] d, output seq_view_t v);
        logic [PHASE_W-1:0] sum;
        int iv;
        case (op)
            OP_TICK:
            begin
                sum = phase + PHASE_W'(tempo) * PHASE_W'(inc);
                if (sum < phase)
                begin
                    play_idx = play_idx + 1'b1;
                    gate_bit = step_on[play_idx];
                    step_advances++;
                end
                phase = sum;
            end
            OP_MODE:
                view_bit = ~view_bit;
            OP_MOVE:
                if (!view_bit)
                    edit_idx = edit_idx + d[STEP_W-1:0];
            OP_INTERVAL:
                if (!view_bit)
                begin
                    iv = int'((32'(k) * 32'd14 + 32'd32768) >> 16) - 7;
                    interval[edit_idx] = 4'(iv);
                end
            OP_TOGGLE:
                if (!view_bit)
                    step_on[edit_idx] = ~step_on[edit_idx];
            OP_TEMPO:
                if (!view_bit)
                    tempo = TEMPO_MIN + TEMPO_W'((32'(k) * 32'd300) >> 16);
            default:
                ;
        endcase

        v.play     = play_idx;
        v.edit     = edit_idx;
        v.gate     = !phase[PHASE_W-1] && gate_bit;
        v.audio_en = step_on[play_idx];
        v.pitch    = just_q8[int'(interval[play_idx]) + 7];
        v.view     = view_bit;
        v.disp     = view_bit ? play_idx : edit_idx;
        v.ind      = view_bit ? gate_bit : step_on[edit_idx];
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("Mismatch in result %0d, %s: expected %0d, got %0d",
                         results_checked, name, want, got);
        end
    endtask

    task automatic compare_result(input seq_view_t want);
        check_field("play_step",    32'(want.play),     32'(m_tdata[2:0]));
        check_field("edit_index",   32'(want.edit),     32'(m_tdata[5:3]));
        check_field("gate_out",     32'(want.gate),     32'(m_tdata[6]));
        check_field("audio_enable", 32'(want.audio_en), 32'(m_tdata[7]));
        check_field("pitch_hz_q8",  32'(want.pitch),    32'(m_tdata[25:8]));
        check_field("display_step", 32'(want.disp),     32'(m_tdata[28:26]));
        check_field("indicator",    32'(want.ind),      32'(m_tdata[29]));
        check_field("padding",      32'd0,              32'(m_tdata[31:30]));
        check_field("view_mode",    32'(want.view),     32'(m_tuser[0]));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_sequencer();
            expected_views.delete();
            fail_count      = 0;
            results_checked = 0;
            step_advances   = 0;
            pending_count  <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                inc = cfg_wr_data;
            if (s_tvalid && s_tready)
            begin
                apply_event(s_tuser, s_tdata[15:0], s_tdata[19:16], fresh_view);
                expected_views.push_back(fresh_view);
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_views.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("Result %0d arrived with no event waiting: data %h, user %b",
                                 results_checked, m_tdata, m_tuser);
                end
                else
                begin
                    oldest_view = expected_views.pop_front();
                    compare_result(oldest_view);
                end
                results_checked++;
            end
            pending_count <= expected_views.size();
        end
    end

endmodule

// ----- tb/sv/tb_step_sequencer_gate_pitch.sv -----
// ----------------------------------------------------------------------------
// tb_step_sequencer_gate_pitch: testbench top of the step sequencer
// Drives directed and random sequencer events under several phase increment
// settings, with random gaps on the input side and random stalls on the
// output side. A separate checker predicts and compares every result; this
// module makes the stimulus, runs a watchdog and reports the verdict.
// ----------------------------------------------------------------------------
module tb_step_sequencer_gate_pitch;
    import sseq_pkg::*;

    localparam op_t OP_SPARE_6  = 3'd6;
    localparam op_t OP_SPARE_7  = 3'd7;
    localparam int  STALL_LIMIT = 2000;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic [15:0] cfg_wr_data   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;
    logic [2:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    logic tx_gaps_on   = 1'b0;
    logic rx_stalls_on = 1'b0;
    int   stall_left   = 0;
    int   quiet_cycles = 0;
    int   events_sent  = 0;
    int   settings_used = 1;
    int   fail_count;
    int   pending_count;
    int   results_checked;
    int   step_advances;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    step_sequencer_gate_pitch i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    sseq_result_checker i_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_tvalid        (s_axis_tvalid),
        .s_tready        (s_axis_tready),
        .s_tdata         (s_axis_tdata),
        .s_tuser         (s_axis_tuser),
        .m_tvalid        (m_axis_tvalid),
        .m_tready        (m_axis_tready),
        .m_tdata         (m_axis_tdata),
        .m_tuser         (m_axis_tuser),
        .fail_count      (fail_count),
        .pending_count   (pending_count),
        .results_checked (results_checked),
        .step_advances   (step_advances)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end
        else if (stall_left != 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (rx_stalls_on && $urandom_range(0, 3) == 0)
                stall_left <= pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= STALL_LIMIT)
        begin
            $display("No transaction for %0d cycles.", STALL_LIMIT);
            $display("Verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_event(input op_t op, input logic [15:0] knob, input logic [3:0] delta);
        int gap;
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {4'b0000, delta, knob};
        do
            @(posedge clk);
        while (!s_axis_tready);
        events_sent++;
    endtask

    task automatic program_increment(input logic [15:0] value);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    task automatic run_random(input int count, input logic gaps, input logic stalls);
        int  r;
        op_t op;
        tx_gaps_on    = gaps;
        rx_stalls_on <= stalls;
        repeat (count)
        begin
            r = $urandom_range(0, 99);
            if (r < 72)
                op = OP_TICK;
            else if (r < 75)
                op = OP_MODE;
            else if (r < 81)
                op = OP_MOVE;
            else if (r < 87)
                op = OP_INTERVAL;
            else if (r < 94)
                op = OP_TOGGLE;
            else if (r < 98)
                op = OP_TEMPO;
            else
                op = r[0] ? OP_SPARE_7 : OP_SPARE_6;
            send_event(op, 16'($urandom_range(0, 65535)), 4'($urandom_range(0, 15)));
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed events at the reset increment, covering field extremes,
        // undefined codes, wrapping edit moves and edits ignored in view mode.
        tx_gaps_on    = 1'b1;
        rx_stalls_on <= 1'b1;
        send_event(OP_TICK,     16'h0000, 4'h0);
        send_event(OP_SPARE_6,  16'hFFFF, 4'h8);
        send_event(OP_SPARE_7,  16'h0000, 4'h7);
        send_event(OP_TOGGLE,   16'h0000, 4'h0);
        send_event(OP_INTERVAL, 16'h0000, 4'h0);
        send_event(OP_INTERVAL, 16'hFFFF, 4'h0);
        send_event(OP_INTERVAL, 16'h8000, 4'h0);
        send_event(OP_INTERVAL, 16'h2492, 4'h0);
        send_event(OP_TEMPO,    16'h0000, 4'h0);
        send_event(OP_TEMPO,    16'hFFFF, 4'h0);
        send_event(OP_MOVE,     16'h0000, 4'hF);
        send_event(OP_MOVE,     16'h0000, 4'h1);
        send_event(OP_MOVE,     16'h0000, 4'h7);
        send_event(OP_MOVE,     16'h0000, 4'h8);
        send_event(OP_TOGGLE,   16'h0000, 4'h0);
        send_event(OP_INTERVAL, 16'hC000, 4'h0);
        send_event(OP_MODE,     16'h0000, 4'h0);
        send_event(OP_MOVE,     16'h0000, 4'h3);
        send_event(OP_INTERVAL, 16'h0000, 4'h0);
        send_event(OP_TOGGLE,   16'h0000, 4'h0);
        send_event(OP_TEMPO,    16'h0000, 4'h0);
        send_event(OP_TICK,     16'hFFFF, 4'hF);
        send_event(OP_MODE,     16'h0000, 4'h0);
        send_event(OP_TICK,     16'h0000, 4'h0);

        program_increment(16'hFFFF);
        run_random(220, 1'b1, 1'b1);
        program_increment(16'd1);
        run_random(50, 1'b1, 1'b0);
        program_increment(16'd0);
        run_random(40, 1'b0, 1'b0);
        program_increment(16'($urandom_range(2, 65534)));
        run_random(100, 1'b0, 1'b1);
        program_increment(16'hFFFF);
        run_random(240, 1'b0, 1'b0);

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d events under %0d phase increment settings; %0d step advances seen.",
                 events_sent, settings_used, step_advances);
        $display("Checked %0d results: %0d mismatches, %0d results never arrived.",
                 results_checked, fail_count, pending_count);
        if (fail_count == 0 && pending_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
